/* rtl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ECMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define ECMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ecms_pkg.sv */
`default_nettype none
package ecms_pkg;
  localparam int unsigned ROWS_DEF         = 4;
  localparam int unsigned MAX_CHUNKS_DEF   = 8;
  localparam int unsigned ROW_CAPACITY_DEF = 4096;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned HASH_W    = 31;
  localparam int unsigned HREG_W    = 62;
  localparam int unsigned PROD_W    = 63;
  localparam int unsigned ROW_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 62;

  // divider: dividend padded to DVD_W bits, BITS_PER_CYC bits per cycle
  localparam int unsigned DVD_W        = 32;
  localparam int unsigned BITS_PER_CYC = 4;
  localparam int unsigned DIV_ITER     = DVD_W / BITS_PER_CYC;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_ROW_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_ROW_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_ROW_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_ROW_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WIDTH  = 3'd4;

  localparam logic [WIDTH_W-1:0] INIT_WIDTH_RST = 13'd256;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_EXPAND = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;
endpackage
`default_nettype wire

/* rtl/ecms_hash.sv */
`default_nettype none
// three-stage hash: multiply, add offset, fold modulo 2^31-1
module ecms_hash (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ecms_pkg::KEY_W-1:0]    key_i,
  input  wire logic [ecms_pkg::HREG_W-1:0]   hash_reg_i,
  output logic                               valid_o,
  output logic [ecms_pkg::HASH_W-1:0]        hash_o
);
  logic [2:0]                       vld_q;
  logic [ecms_pkg::PROD_W-1:0]      prod_q;
  logic [ecms_pkg::PROD_W-1:0]      sum_q;
  logic [ecms_pkg::HASH_W-1:0]      ofs_q;
  logic [ecms_pkg::HASH_W-1:0]      hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ecms_pkg::PROD_W'(hash_reg_i[61:31]) * ecms_pkg::PROD_W'(key_i);
    ofs_q  <= hash_reg_i[30:0];
    sum_q  <= prod_q + ecms_pkg::PROD_W'(ofs_q);
    hash_q <= sum_q[61:31] + sum_q[30:0];
  end

  assign valid_o = vld_q[2];
  assign hash_o  = hash_q;
endmodule
`default_nettype wire

/* rtl/ecms_mod.sv */
`default_nettype none
// iterative restoring remainder, several bits per cycle
module ecms_mod #(
  parameter int unsigned CW = 13
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ecms_pkg::HASH_W-1:0] dividend_i,
  input  wire logic [CW-1:0]               divisor_i,
  output logic                             done_o,
  output logic [CW-1:0]                    rem_o
);
  localparam int unsigned CNT_W = (ecms_pkg::DIV_ITER > 1) ? $clog2(ecms_pkg::DIV_ITER) : 1;

  logic                         run_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [CW:0]                  rem_q, rem_d;
  logic [ecms_pkg::DVD_W-1:0]   dvd_q, dvd_d;
  logic [CW-1:0]                div_q;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < ecms_pkg::BITS_PER_CYC; k++) begin
      rem_d = {rem_d[CW-1:0], dvd_d[ecms_pkg::DVD_W-1]};
      dvd_d = {dvd_d[ecms_pkg::DVD_W-2:0], 1'b0};
      if (rem_d >= {1'b0, div_q}) begin
        rem_d = rem_d - {1'b0, div_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ecms_pkg::DIV_ITER - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= {{(ecms_pkg::DVD_W - ecms_pkg::HASH_W){1'b0}}, dividend_i};
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[CW-1:0];
endmodule
`default_nettype wire

/* rtl/expanding_count_min_sketch_core.sv */
// an expand request is answered in the next cycle; an update request is paced by the shared
//   remainder unit (8 iterations per chunk per row), the hash run once per row and the
//   single counter memory port
// throughput: one request at a time, busy_o high while an update runs; results cannot be stalled
// reset: counter store cleared by a pass over all ROWS*ROW_CAPACITY cells (16384 by default),
//   busy_o high meanwhile; the same pass runs after a write of initial_width
`default_nettype none
module expanding_count_min_sketch_core #(
  parameter int unsigned ROWS         = ecms_pkg::ROWS_DEF,
  parameter int unsigned MAX_CHUNKS   = ecms_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned ROW_CAPACITY = ecms_pkg::ROW_CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              mode_i,
  input  wire logic [ecms_pkg::KEY_W-1:0]        item_key_i,
  input  wire logic signed [ecms_pkg::DATA_W-1:0] diff_i,
  input  wire logic [ecms_pkg::WIDTH_W-1:0]      expand_width_i,
  // result channel
  output logic                                   done_o,
  output logic signed [ecms_pkg::DATA_W-1:0]     estimate_o,
  output logic signed [ecms_pkg::DATA_W-1:0]     total_count_o,
  output logic                                   status_o,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ecms_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ecms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  // widths derived from the parameters
  localparam int unsigned DEPTH  = ROWS * ROW_CAPACITY;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(ROW_CAPACITY + 1);   // cumulative width
  localparam int unsigned PW     = $clog2(ROW_CAPACITY);       // position in a row
  localparam int unsigned CIW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CCW    = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SW     = ((CW > ecms_pkg::WIDTH_W) ? CW : ecms_pkg::WIDTH_W) + 1;
  localparam int unsigned DW     = ecms_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD_GO, S_MOD, S_UPD_RD, S_UPD_WR,
    S_SUM_RD, S_SUM_ACC, S_MIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ecms_pkg::HREG_W-1:0] hash_row_q [4];

  // chunk table
  logic [CW-1:0]  bounds_q [MAX_CHUNKS];
  logic [CCW-1:0] chunk_cnt_q;
  logic [CW-1:0]  last_bound_q;     // cumulative bound of the newest chunk
  logic [DW-1:0]  total_q;

  // per request working state
  logic [ecms_pkg::KEY_W-1:0]   key_q;
  logic [DW-1:0]                diff_q;
  logic [ecms_pkg::ROW_IDX_W-1:0] row_q;
  logic [ADDR_W-1:0]            base_q;
  logic [ecms_pkg::HASH_W-1:0]  hash_q;
  logic [CIW-1:0]               cidx_q;
  logic [CW-1:0]                prev_q;
  logic [PW-1:0]                target_q;
  logic [PW-1:0]                pos_q [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0]        match_q;
  logic [DW-1:0]                sum_q;
  logic [DW-1:0]                est_q;
  logic                         first_q;
  logic                         hash_go_q;
  logic                         mod_go_q;
  logic [ADDR_W-1:0]            clr_q;

  // registered results
  logic          done_q;
  logic [DW-1:0] est_out_q;
  logic          status_q;

  // counter memory
  logic [DW-1:0]     mem [DEPTH];
  logic [DW-1:0]     rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DW-1:0]     mem_wdata;

  // shared units
  logic                        hash_vld;
  logic [ecms_pkg::HASH_W-1:0] hash_val;
  logic                        mod_done;
  logic [CW-1:0]               mod_rem;

  ecms_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_go_q),
    .key_i      (key_q),
    .hash_reg_i (hash_row_q[row_q]),
    .valid_o    (hash_vld),
    .hash_o     (hash_val)
  );

  ecms_mod #(.CW(CW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_go_q),
    .dividend_i (hash_q),
    .divisor_i  (bounds_q[cidx_q]),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // initial width clamped into 1..ROW_CAPACITY
  logic [CW-1:0] cfg_width;
  always_comb begin
    logic [SW-1:0] w;
    w = SW'(cfg_data_i[ecms_pkg::WIDTH_W-1:0]);
    if (w == '0) begin
      cfg_width = CW'(1);
    end else if (w > SW'(ROW_CAPACITY)) begin
      cfg_width = CW'(ROW_CAPACITY);
    end else begin
      cfg_width = CW'(w);
    end
  end

  // expansion check
  logic [SW-1:0] new_bound;
  logic          exp_refused;
  assign new_bound   = SW'(last_bound_q) + SW'(expand_width_i);
  assign exp_refused = (expand_width_i == '0) || (chunk_cnt_q >= CCW'(MAX_CHUNKS)) ||
                       (new_bound > SW'(ROW_CAPACITY));

  logic start_ok;
  assign start_ok = start_i && (state_q == S_IDLE);

  logic cidx_last;
  assign cidx_last = (CCW'(cidx_q) + 1'b1) >= chunk_cnt_q;

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = base_q + ADDR_W'(target_q);
    mem_wdata = rdata_q + diff_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      S_UPD_RD:  mem_re = 1'b1;
      S_UPD_WR:  mem_we = 1'b1;
      S_SUM_RD: begin
        mem_re   = 1'b1;
        mem_addr = base_q + ADDR_W'(pos_q[cidx_q]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // hash register writes take effect at any time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) hash_row_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecms_pkg::REG_HASH_ROW_0: hash_row_q[0] <= cfg_data_i;
        ecms_pkg::REG_HASH_ROW_1: hash_row_q[1] <= cfg_data_i;
        ecms_pkg::REG_HASH_ROW_2: hash_row_q[2] <= cfg_data_i;
        ecms_pkg::REG_HASH_ROW_3: hash_row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      for (int i = 1; i < MAX_CHUNKS; i++) bounds_q[i] <= '0;
      bounds_q[0]  <= CW'(ecms_pkg::INIT_WIDTH_RST > ROW_CAPACITY ?
                          ROW_CAPACITY : ecms_pkg::INIT_WIDTH_RST);
      last_bound_q <= CW'(ecms_pkg::INIT_WIDTH_RST > ROW_CAPACITY ?
                          ROW_CAPACITY : ecms_pkg::INIT_WIDTH_RST);
      chunk_cnt_q  <= CCW'(1);
      total_q      <= '0;
      clr_q        <= '0;
      done_q       <= 1'b0;
      est_out_q    <= '0;
      status_q     <= ecms_pkg::STATUS_OK;
      hash_go_q    <= 1'b0;
      mod_go_q     <= 1'b0;
      row_q        <= '0;
      cidx_q       <= '0;
      first_q      <= 1'b0;
    end else begin
      done_q    <= 1'b0;
      hash_go_q <= 1'b0;
      mod_go_q  <= 1'b0;
      if (cfg_we_i && (cfg_idx_i == ecms_pkg::REG_INIT_WIDTH)) begin
        // a new initial width restarts the sketch
        for (int i = 1; i < MAX_CHUNKS; i++) bounds_q[i] <= '0;
        bounds_q[0]  <= cfg_width;
        last_bound_q <= cfg_width;
        chunk_cnt_q  <= CCW'(1);
        total_q      <= '0;
        clr_q        <= '0;
        state_q      <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + 1'b1;
            if (clr_q == ADDR_W'(DEPTH - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start_ok) begin
              if (mode_i == ecms_pkg::MODE_EXPAND) begin
                done_q    <= 1'b1;
                est_out_q <= '0;
                if (exp_refused) begin
                  status_q <= ecms_pkg::STATUS_REFUSED;
                end else begin
                  status_q                         <= ecms_pkg::STATUS_OK;
                  bounds_q[chunk_cnt_q[CIW-1:0]]   <= CW'(new_bound);
                  last_bound_q                     <= CW'(new_bound);
                  chunk_cnt_q                      <= chunk_cnt_q + 1'b1;
                end
              end else begin
                total_q   <= total_q + diff_i;
                key_q     <= item_key_i;
                diff_q    <= diff_i;
                row_q     <= '0;
                base_q    <= '0;
                first_q   <= 1'b1;
                hash_go_q <= 1'b1;
                state_q   <= S_HASH;
              end
            end
          end
          S_HASH: begin
            if (hash_vld) begin
              hash_q   <= hash_val;
              cidx_q   <= '0;
              prev_q   <= '0;
              mod_go_q <= 1'b1;
              state_q  <= S_MOD;
            end
          end
          S_MOD_GO: begin
            mod_go_q <= 1'b1;
            state_q  <= S_MOD;
          end
          S_MOD: begin
            if (mod_done) begin
              // newest chunk whose range holds the position wins the update
              pos_q[cidx_q]   <= PW'(mod_rem);
              match_q[cidx_q] <= (mod_rem >= prev_q);
              if ((mod_rem >= prev_q) || (cidx_q == '0)) begin
                target_q <= PW'(mod_rem);
              end
              prev_q <= bounds_q[cidx_q];
              if (cidx_last) begin
                state_q <= S_UPD_RD;
              end else begin
                cidx_q  <= cidx_q + 1'b1;
                state_q <= S_MOD_GO;
              end
            end
          end
          S_UPD_RD: state_q <= S_UPD_WR;
          S_UPD_WR: begin
            cidx_q  <= '0;
            sum_q   <= '0;
            state_q <= S_SUM_RD;
          end
          S_SUM_RD: state_q <= S_SUM_ACC;
          S_SUM_ACC: begin
            if (match_q[cidx_q]) begin
              sum_q <= sum_q + rdata_q;
            end
            if (cidx_last) begin
              state_q <= S_MIN;
            end else begin
              cidx_q  <= cidx_q + 1'b1;
              state_q <= S_SUM_RD;
            end
          end
          S_MIN: begin
            // signed minimum over rows
            if (first_q || ($signed(sum_q) < $signed(est_q))) begin
              est_q <= sum_q;
            end
            first_q <= 1'b0;
            if (row_q == ecms_pkg::ROW_IDX_W'(ROWS - 1)) begin
              done_q    <= 1'b1;
              status_q  <= ecms_pkg::STATUS_OK;
              est_out_q <= (first_q || ($signed(sum_q) < $signed(est_q))) ? sum_q : est_q;
              state_q   <= S_IDLE;
            end else begin
              row_q     <= row_q + 1'b1;
              base_q    <= base_q + ADDR_W'(ROW_CAPACITY);
              hash_go_q <= 1'b1;
              state_q   <= S_HASH;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign estimate_o    = est_out_q;
  assign total_count_o = total_q;
  assign status_o      = status_q;
endmodule
`default_nettype wire

/* rtl/ecms_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module ecms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        mode_i,
  input wire logic        done_o,
  input wire logic [31:0] estimate_o,
  input wire logic        status_o
);
  // expand request answers in the next cycle
  `ECMS_ASSERT_NEXT(a_expand_done, clk_i, rst_ni, start_i && !busy_o && mode_i, done_o)
  // update request makes the block busy
  `ECMS_ASSERT_NEXT(a_update_busy, clk_i, rst_ni, start_i && !busy_o && !mode_i, busy_o)
  // refused expansion reports a zero estimate
  `ECMS_ASSERT_SAME(a_refused_zero, clk_i, rst_ni, done_o && status_o, estimate_o == 32'd0)
endmodule

bind expanding_count_min_sketch_core ecms_checker u_ecms_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .mode_i     (mode_i),
  .done_o     (done_o),
  .estimate_o (estimate_o),
  .status_o   (status_o)
);
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ROWS   = ecms_pkg::ROWS_DEF;
  localparam int unsigned NUM_CHUNKS = ecms_pkg::MAX_CHUNKS_DEF;
  localparam int unsigned ROW_CAP    = ecms_pkg::ROW_CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned RANDOM_PER_PHASE = 306;
  localparam int unsigned NUM_PHASES = 6;

  localparam int unsigned KW  = ecms_pkg::KEY_W;
  localparam int unsigned DW  = ecms_pkg::DATA_W;
  localparam int unsigned EWW = ecms_pkg::WIDTH_W;
  localparam int unsigned IW  = ecms_pkg::CFG_IDX_W;
  localparam int unsigned CDW = ecms_pkg::CFG_DATA_W;
  localparam int unsigned HW  = ecms_pkg::HREG_W;

  localparam logic M_UPD  = ecms_pkg::MODE_UPDATE;
  localparam logic M_EXP  = ecms_pkg::MODE_EXPAND;
  localparam logic ST_OK  = ecms_pkg::STATUS_OK;
  localparam logic ST_REF = ecms_pkg::STATUS_REFUSED;

  logic clk_i, rst_ni;
  logic start_i, busy_o, mode_i, done_o, status_o, cfg_we_i;
  logic [KW-1:0] item_key_i;
  logic signed [DW-1:0] diff_i, estimate_o, total_count_o;
  logic [EWW-1:0] expand_width_i;
  logic [IW-1:0] cfg_idx_i;
  logic [CDW-1:0] cfg_data_i;

  expanding_count_min_sketch_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .item_key_i, .diff_i, .expand_width_i,
    .done_o, .estimate_o, .total_count_o, .status_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // one sketch answer
  typedef struct packed {
    logic [DW-1:0] est;
    logic [DW-1:0] tot;
    logic          st;
  } answer_t;

  // directed stimulus row, typed answer used when has_ans is set
  typedef struct {
    logic           mode;
    logic [KW-1:0]  key;
    logic [DW-1:0]  amount;
    logic [EWW-1:0] ew;
    bit             has_ans;
    answer_t        ans;
  } vector_t;

  answer_t pending_answers[$];
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;

  // shadow of the sketch
  logic [HW-1:0]  hash_regs[NUM_ROWS];
  logic [EWW-1:0] init_width_reg;
  logic [DW-1:0]  sketch_cells[NUM_ROWS*ROW_CAP];
  int unsigned    cum_bounds[NUM_CHUNKS];
  int unsigned    num_chunks;
  logic [DW-1:0]  running_total;

  logic [KW-1:0] hot_keys[16];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // results cannot be held off, take each one at the edge ending its strobe
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result est=%0h tot=%0h st=%0b", estimate_o, total_count_o, status_o);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (estimate_o !== want.est) begin
          $error("estimate: expected %0h actual %0h", want.est, estimate_o);
          fail_count++;
        end
        if (total_count_o !== want.tot) begin
          $error("total_count: expected %0h actual %0h", want.tot, total_count_o);
          fail_count++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0b actual %0b", want.st, status_o);
          fail_count++;
        end
      end
    end
  end

  // store clear, single chunk of the configured width
  function automatic void clear_sketch();
    int unsigned w;
    w = init_width_reg;
    if (w == 0) w = 1;
    if (w > ROW_CAP) w = ROW_CAP;
    foreach (sketch_cells[i]) sketch_cells[i] = '0;
    foreach (cum_bounds[i]) cum_bounds[i] = 0;
    cum_bounds[0] = w;
    num_chunks = 1;
    running_total = '0;
  endfunction

  // (a*x+b) folded modulo 2^31-1
  function automatic longint unsigned row_hash31(int unsigned r, logic [KW-1:0] key);
    longint unsigned a, b, t;
    a = longint'(hash_regs[r][61:31]);
    b = longint'(hash_regs[r][30:0]);
    t = a * longint'(key) + b;
    t = ((t >> 31) + t) & 64'h7FFF_FFFF;
    return t;
  endfunction

  function automatic answer_t sketch_step(logic mode, logic [KW-1:0] key,
                                          logic [DW-1:0] amount, logic [EWW-1:0] ew);
    answer_t res;
    int unsigned last, prev, pos, tgt, base;
    longint unsigned h;
    logic [DW-1:0] sum;
    bit first;
    res = '0;
    first = 1;
    if (mode == M_EXP) begin
      last = cum_bounds[num_chunks-1];
      if (ew == 0 || num_chunks >= NUM_CHUNKS || last + ew > ROW_CAP) begin
        res.st = ST_REF;
      end else begin
        cum_bounds[num_chunks] = last + ew;
        num_chunks++;
      end
    end else begin
      running_total = running_total + amount;
      for (int unsigned r = 0; r < NUM_ROWS; r++) begin
        h = row_hash31(r, key);
        base = r * ROW_CAP;
        // newest matching chunk takes the update
        tgt = 32'(h % cum_bounds[0]);
        prev = 0;
        for (int unsigned c = 0; c < num_chunks; c++) begin
          pos = 32'(h % cum_bounds[c]);
          if (pos >= prev) tgt = pos;
          prev = cum_bounds[c];
        end
        sketch_cells[base+tgt] = sketch_cells[base+tgt] + amount;
        // row estimate sums every matching chunk
        sum = '0;
        prev = 0;
        for (int unsigned c = 0; c < num_chunks; c++) begin
          pos = 32'(h % cum_bounds[c]);
          if (pos >= prev) sum = sum + sketch_cells[base+pos];
          prev = cum_bounds[c];
        end
        if (first || $signed(sum) < $signed(res.est)) begin
          res.est = sum;
          first = 0;
        end
      end
    end
    res.tot = running_total;
    return res;
  endfunction

  // present one request, return at the edge that accepts it
  task automatic issue(logic mode, logic [KW-1:0] key, logic [DW-1:0] amount,
                       logic [EWW-1:0] ew, bit has_ans, answer_t typed);
    answer_t pred;
    start_i <= 1'b1;
    mode_i <= mode;
    item_key_i <= key;
    diff_i <= amount;
    expand_width_i <= ew;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = sketch_step(mode, key, amount, ew);
    pending_answers.insert(pending_answers.size(), has_ans ? typed : pred);
  endtask

  // drop start and let every outstanding result arrive
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [IW-1:0] idx, logic [CDW-1:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    if (idx == ecms_pkg::REG_INIT_WIDTH) begin
      init_width_reg = data[EWW-1:0];
      clear_sketch();
    end else begin
      hash_regs[idx] = data;
    end
  endtask

  function automatic logic [CDW-1:0] rand_hash();
    return CDW'({$urandom(), $urandom()});
  endfunction

  // mostly hot keys so counters collide and estimates grow
  task automatic random_request(int unsigned idle_pct);
    logic mode;
    logic [KW-1:0] key;
    logic [DW-1:0] amount;
    logic [EWW-1:0] ew;
    int unsigned pick;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    mode = ($urandom_range(99) < 7) ? M_EXP : M_UPD;
    key = ($urandom_range(99) < 70) ? hot_keys[$urandom_range(15)] : $urandom();
    pick = $urandom_range(99);
    if (pick < 50) amount = DW'($urandom_range(16) - 8);
    else if (pick < 60) amount = '0;
    else amount = $urandom();
    pick = $urandom_range(99);
    if (pick < 80) ew = EWW'($urandom_range(1, 300));
    else if (pick < 85) ew = '0;
    else if (pick < 90) ew = 13'd4096;
    else if (pick < 95) ew = 13'd1;
    else ew = EWW'($urandom_range(1, 4096));
    issue(mode, key, amount, ew, 0, '0);
  endtask

  // answers readable by hand: after reset every hash is zero, so every key hits position 0
  vector_t directed[] = '{
    '{M_UPD, 32'h0,        32'h0,        13'd0,    1, '{32'h0,        32'h0,        ST_OK}},
    '{M_UPD, 32'hFFFFFFFF, 32'h7FFFFFFF, 13'd0,    1, '{32'h7FFFFFFF, 32'h7FFFFFFF, ST_OK}},
    '{M_UPD, 32'h1,        32'h1,        13'd0,    1, '{32'h80000000, 32'h80000000, ST_OK}},
    '{M_UPD, 32'h2,        32'h80000000, 13'd0,    1, '{32'h0,        32'h0,        ST_OK}},
    '{M_EXP, 32'hFFFFFFFF, 32'hFFFFFFFF, 13'd0,    1, '{32'h0,        32'h0,        ST_REF}},
    '{M_EXP, 32'h0,        32'h0,        13'd4096, 1, '{32'h0,        32'h0,        ST_REF}},
    '{M_EXP, 32'h0,        32'h0,        13'd3840, 1, '{32'h0,        32'h0,        ST_OK}},
    '{M_EXP, 32'h0,        32'h0,        13'd1,    1, '{32'h0,        32'h0,        ST_REF}},
    '{M_UPD, 32'd123,      32'hFFFFFFFB, 13'd0,    1, '{32'hFFFFFFFB, 32'hFFFFFFFB, ST_OK}},
    '{M_UPD, 32'h55555555, 32'h0,        13'd0,    0, '{32'h0, 32'h0, ST_OK}},
    '{M_UPD, 32'hAAAAAAAA, 32'hFFFFFFFF, 13'd0,    0, '{32'h0, 32'h0, ST_OK}},
    '{M_UPD, 32'h80000000, 32'h12345678, 13'd0,    0, '{32'h0, 32'h0, ST_OK}}
  };

  // per phase: sender idle percentage and first chunk width
  int unsigned idle_pcts[NUM_PHASES] = '{0, 67, 0, 9, 67, 0};
  int unsigned first_widths[NUM_PHASES] = '{256, 1, 4096, 17, 1000, 64};

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = M_UPD;
    item_key_i = '0;
    diff_i = '0;
    expand_width_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ecms_pkg::REG_HASH_ROW_0;
    cfg_data_i = '0;
    foreach (hash_regs[i]) hash_regs[i] = '0;
    init_width_reg = ecms_pkg::INIT_WIDTH_RST;
    clear_sketch();
    foreach (hot_keys[i]) hot_keys[i] = $urandom();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      issue(directed[i].mode, directed[i].key, directed[i].amount, directed[i].ew,
            directed[i].has_ans, directed[i].ans);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        // hash settings: all ones, then random with row 3 zero, then all random
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (p == 1) write_reg(IW'(ecms_pkg::REG_HASH_ROW_0 + r), '1);
          else if (p == 2 && r == 3) write_reg(IW'(ecms_pkg::REG_HASH_ROW_0 + r), '0);
          else write_reg(IW'(ecms_pkg::REG_HASH_ROW_0 + r), rand_hash());
        end
        write_reg(ecms_pkg::REG_INIT_WIDTH, CDW'(first_widths[p]));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_request(idle_pcts[p]);
        // sender holds off until the sketch is quiet
        if (n == RANDOM_PER_PHASE / 2 && p == 3) drain();
      end
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
